@@ rtl/core/wfcd_pkg.sv @@
package wfcd_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int IDX_W       = 4;
	localparam int TGT_W       = 4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FOLLOW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic chk_clear;
		logic walk_start;
		logic walk_step;
		logic walk_end;
		logic skip;
		logic set_hit;
		logic set_none;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic scan_end;
		logic start_ok;
		logic tgt_stop;
		logic tgt_new;
		logic tgt_waits;
		logic tgt_on_path;
	} status_t;

endpackage

@@ rtl/core/wfcd_ifs.sv @@
interface wfcd_req_if;
	logic                      valid;
	logic                      ready;
	logic                      op;
	logic [wfcd_pkg::IDX_W-1:0] entry_index;
	logic                      is_introduced;
	logic                      is_held;
	logic                      is_waiting;
	logic [wfcd_pkg::TGT_W-1:0] wait_target;

	modport source (
		output valid, op, entry_index, is_introduced, is_held, is_waiting, wait_target,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, is_introduced, is_held, is_waiting, wait_target,
		output ready
	);
endinterface

interface wfcd_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      deadlock_found;
	logic [wfcd_pkg::IDX_W-1:0] cycle_entry;

	modport source (
		output valid, deadlock_found, cycle_entry,
		input  ready
	);
	modport sink (
		input  valid, deadlock_found, cycle_entry,
		output ready
	);
endinterface

@@ rtl/core/wfcd_ram.sv @@
module wfcd_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/wfcd_ctrl.sv @@
module wfcd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_op,
	input  logic              out_ready,
	input  wfcd_pkg::status_t status,
	output wfcd_pkg::cmd_t    cmd,
	output logic              in_ready,
	output logic              out_valid
);

	wfcd_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == wfcd_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wfcd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_op == wfcd_pkg::OP_WRITE) ? wfcd_pkg::ST_DONE
						: wfcd_pkg::ST_SCAN;
				end
			end
			wfcd_pkg::ST_SCAN: begin
				if (status.scan_end) begin
					state_d = wfcd_pkg::ST_DONE;
				end else if (status.start_ok) begin
					state_d = wfcd_pkg::ST_FOLLOW;
				end
			end
			wfcd_pkg::ST_FOLLOW: begin
				if (status.tgt_stop) begin
					state_d = wfcd_pkg::ST_SCAN;
				end else if (status.tgt_new) begin
					if (!status.tgt_waits) begin
						state_d = wfcd_pkg::ST_SCAN;
					end
				end else if (status.tgt_on_path) begin
					state_d = wfcd_pkg::ST_DONE;
				end else begin
					state_d = wfcd_pkg::ST_SCAN;
				end
			end
			wfcd_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = wfcd_pkg::ST_IDLE;
				end
			end
			default: state_d = wfcd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			wfcd_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_op == wfcd_pkg::OP_WRITE) begin
						cmd.wr_en    = 1'b1;
						cmd.set_none = 1'b1;
					end else begin
						cmd.chk_clear = 1'b1;
					end
				end
			end
			wfcd_pkg::ST_SCAN: begin
				if (status.scan_end) begin
					cmd.set_none = 1'b1;
				end else if (status.start_ok) begin
					cmd.walk_start = 1'b1;
				end else begin
					cmd.skip = 1'b1;
				end
			end
			wfcd_pkg::ST_FOLLOW: begin
				if (status.tgt_stop) begin
					cmd.walk_end = 1'b1;
				end else if (status.tgt_new) begin
					cmd.walk_step = 1'b1;
					cmd.walk_end  = !status.tgt_waits;
				end else if (status.tgt_on_path) begin
					cmd.set_hit = 1'b1;
				end else begin
					cmd.walk_end = 1'b1;
				end
			end
			wfcd_pkg::ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wfcd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/wfcd_dp.sv @@
module wfcd_dp #(
	parameter int ENTRIES = wfcd_pkg::ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wfcd_pkg::cmd_t             cmd,
	input  logic [wfcd_pkg::IDX_W-1:0] entry_index,
	input  logic                       is_introduced,
	input  logic                       is_held,
	input  logic                       is_waiting,
	input  logic [wfcd_pkg::TGT_W-1:0] wait_target,
	output wfcd_pkg::status_t          status,
	output logic                       deadlock_found,
	output logic [wfcd_pkg::IDX_W-1:0] cycle_entry
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	logic [ENTRIES-1:0] intro_q, held_q, wait_q, visited_q, on_path_q;
	logic [CW-1:0]      i_q;
	logic [IW-1:0]      i_ix, nxt_ix, w_ix, raddr;
	logic [wfcd_pkg::TGT_W-1:0] rdata;
	logic               w_in, tgt_in, ram_we;
	logic               res_found_q, out_found_q;
	logic [wfcd_pkg::IDX_W-1:0] res_hit_q, out_hit_q;

	assign i_ix   = i_q[IW-1:0];
	assign w_ix   = IW'(entry_index);
	assign w_in   = (32'(entry_index) < ENTRIES);
	assign nxt_ix = IW'(rdata);
	assign tgt_in = (32'(rdata) < ENTRIES);
	assign ram_we = cmd.wr_en && w_in;
	assign raddr  = cmd.walk_start ? i_ix : nxt_ix;

	wfcd_ram #(
		.WIDTH(wfcd_pkg::TGT_W),
		.DEPTH(ENTRIES)
	) u_tgt_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(w_ix),
		.wdata(wait_target),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		status.scan_end    = (i_q == CW'(ENTRIES));
		status.start_ok    = !status.scan_end && intro_q[i_ix] && held_q[i_ix]
			&& wait_q[i_ix] && !visited_q[i_ix];
		status.tgt_stop    = !(tgt_in && intro_q[nxt_ix]);
		status.tgt_new     = tgt_in && !visited_q[nxt_ix];
		status.tgt_waits   = tgt_in && wait_q[nxt_ix];
		status.tgt_on_path = tgt_in && on_path_q[nxt_ix];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intro_q   <= '0;
			held_q    <= '0;
			wait_q    <= '0;
			visited_q <= '0;
			on_path_q <= '0;
			i_q       <= '0;
		end else begin
			if (ram_we) begin
				intro_q[w_ix] <= is_introduced;
				held_q[w_ix]  <= is_held;
				wait_q[w_ix]  <= is_waiting;
			end
			if (cmd.chk_clear) begin
				visited_q <= '0;
				on_path_q <= '0;
				i_q       <= '0;
			end else begin
				if (cmd.walk_start) begin
					visited_q[i_ix] <= 1'b1;
					on_path_q[i_ix] <= 1'b1;
				end
				if (cmd.walk_step) begin
					visited_q[nxt_ix] <= 1'b1;
				end
				if (cmd.walk_end) begin
					on_path_q <= '0;
				end else if (cmd.walk_step) begin
					on_path_q[nxt_ix] <= 1'b1;
				end
				if (cmd.walk_end || cmd.skip) begin
					i_q <= i_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_none) begin
			res_found_q <= 1'b0;
			res_hit_q   <= '0;
		end else if (cmd.set_hit) begin
			res_found_q <= 1'b1;
			res_hit_q   <= rdata;
		end
		if (cmd.out_load) begin
			out_found_q <= res_found_q;
			out_hit_q   <= res_hit_q;
		end
	end

	assign deadlock_found = out_found_q;
	assign cycle_entry    = out_hit_q;

endmodule

@@ rtl/core/wait_for_cycle_detector.sv @@
// Wait-for cycle detector. A write beat updates one table entry (introduced, held,
// waiting, wait target) and yields a result with no deadlock. A check beat scans the
// entries in index order and follows wait pointers from each unvisited introduced,
// held, waiting entry, reporting the first entry revisited on the current path. The
// scan pointer and the walk share one wait-target memory read port, so a check reads
// the scanned indices and the entries visited by the walks one after another. One
// item is worked on at a time; a new beat is taken while the previous result still
// waits in the output register.
module wait_for_cycle_detector #(
	parameter int ENTRIES = wfcd_pkg::ENTRIES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	wfcd_req_if.sink    req,
	wfcd_rsp_if.source  rsp
);

	wfcd_pkg::cmd_t    cmd;
	wfcd_pkg::status_t status;

	wfcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req.op),
		.out_ready(rsp.ready),
		.status   (status),
		.cmd      (cmd),
		.in_ready (req.ready),
		.out_valid(rsp.valid)
	);

	wfcd_dp #(
		.ENTRIES(ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.entry_index   (req.entry_index),
		.is_introduced (req.is_introduced),
		.is_held       (req.is_held),
		.is_waiting    (req.is_waiting),
		.wait_target   (req.wait_target),
		.status        (status),
		.deadlock_found(rsp.deadlock_found),
		.cycle_entry   (rsp.cycle_entry)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("input taken while previous item still in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.deadlock_found) |-> (rsp.cycle_entry == '0))
		else $error("nonzero cycle entry without deadlock");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.deadlock_found) |-> (32'(rsp.cycle_entry) < ENTRIES))
		else $error("cycle entry outside table");

	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.op == wfcd_pkg::OP_WRITE) |=> !rsp.valid
			|| $past(rsp.valid))
		else $error("write result appeared without pass through done");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam int N_ENTRIES = wfcd_pkg::ENTRIES_DEF;
	localparam int IW        = wfcd_pkg::IDX_W;
	localparam int TW        = wfcd_pkg::TGT_W;
	localparam int N_ITEMS   = 1650;
	localparam int TAIL_WAIT = 2 * N_ENTRIES + 16;

	typedef struct packed {
		logic          op;
		logic [IW-1:0] entry_index;
		logic          is_introduced;
		logic          is_held;
		logic          is_waiting;
		logic [TW-1:0] wait_target;
	} beat_t;

	typedef struct packed {
		logic          deadlock_found;
		logic [IW-1:0] cycle_entry;
	} verdict_t;

	logic clk;
	logic arst_n;

	wfcd_req_if req_if ();
	wfcd_rsp_if rsp_if ();

	wait_for_cycle_detector #(
		.ENTRIES(N_ENTRIES)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if.sink),
		.rsp   (rsp_if.source)
	);

	// mirror of the resource table
	logic          tbl_intro [N_ENTRIES];
	logic          tbl_held  [N_ENTRIES];
	logic          tbl_wait  [N_ENTRIES];
	logic [TW-1:0] tbl_tgt   [N_ENTRIES];

	beat_t    pending_beats[$];
	verdict_t expected_verdicts[$];
	beat_t    offered;

	int   n_queued;
	int   n_accepted;
	int   n_checks;
	int   n_deadlocks;
	int   n_results;
	int   n_errors;
	int   send_gap;
	int   recv_stall;
	int   cycle_cnt;
	int   beats_seen;
	int   hold_left;
	logic hold_done;
	logic rsp_hold;
	logic quiet;

	function automatic verdict_t predict_beat(input beat_t b);
		verdict_t             v;
		logic [N_ENTRIES-1:0] seen;
		logic [N_ENTRIES-1:0] path;
		int                   i;
		int                   steps;
		int                   node;
		int                   nxt;
		logic                 done;
		v = '0;
		if (b.op == wfcd_pkg::OP_WRITE) begin
			if (b.entry_index < N_ENTRIES) begin
				tbl_intro[b.entry_index] = b.is_introduced;
				tbl_held[b.entry_index]  = b.is_held;
				tbl_wait[b.entry_index]  = b.is_waiting;
				tbl_tgt[b.entry_index]   = b.wait_target;
			end
		end else begin
			seen = '0;
			for (i = 0; i < N_ENTRIES; i++) begin
				if (!v.deadlock_found && tbl_intro[i] && tbl_held[i] && tbl_wait[i]
						&& !seen[i]) begin
					path = '0;
					node = i;
					done = 1'b0;
					for (steps = 0; steps <= N_ENTRIES && !done; steps++) begin
						seen[node] = 1'b1;
						path[node] = 1'b1;
						nxt = int'(tbl_tgt[node]);
						if (!tbl_wait[node] || nxt >= N_ENTRIES || !tbl_intro[nxt]) begin
							done = 1'b1;
						end else if (!seen[nxt]) begin
							node = nxt;
						end else begin
							done = 1'b1;
							if (path[nxt]) begin
								v.deadlock_found = 1'b1;
								v.cycle_entry    = nxt[IW-1:0];
							end
						end
					end
				end
			end
		end
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 40);
	endfunction

	task automatic put_write(input int idx, input int intro, input int held,
			input int waiting, input int tgt);
		beat_t b;
		b.op            = wfcd_pkg::OP_WRITE;
		b.entry_index   = idx[IW-1:0];
		b.is_introduced = intro[0];
		b.is_held       = held[0];
		b.is_waiting    = waiting[0];
		b.wait_target   = tgt[TW-1:0];
		pending_beats.push_back(b);
		n_queued++;
	endtask

	task automatic put_check();
		beat_t b;
		b.op            = wfcd_pkg::OP_CHECK;
		b.entry_index   = IW'($urandom_range(0, 15));
		b.is_introduced = 1'($urandom_range(0, 1));
		b.is_held       = 1'($urandom_range(0, 1));
		b.is_waiting    = 1'($urandom_range(0, 1));
		b.wait_target   = TW'($urandom_range(0, 15));
		pending_beats.push_back(b);
		n_queued++;
	endtask

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		req_if.valid         = 1'b0;
		req_if.op            = wfcd_pkg::OP_WRITE;
		req_if.entry_index   = '0;
		req_if.is_introduced = 1'b0;
		req_if.is_held       = 1'b0;
		req_if.is_waiting    = 1'b0;
		req_if.wait_target   = '0;
		rsp_if.ready         = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

	// sender side
	always @(posedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				expected_verdicts.push_back(predict_beat(offered));
				n_accepted++;
				if (offered.op == wfcd_pkg::OP_CHECK)
					n_checks++;
				send_gap = pick_gap();
			end
			if (!req_if.valid || req_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_if.valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					offered = pending_beats.pop_front();
					req_if.valid         <= 1'b1;
					req_if.op            <= offered.op;
					req_if.entry_index   <= offered.entry_index;
					req_if.is_introduced <= offered.is_introduced;
					req_if.is_held       <= offered.is_held;
					req_if.is_waiting    <= offered.is_waiting;
					req_if.wait_target   <= offered.wait_target;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver side
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				got.deadlock_found = rsp_if.deadlock_found;
				got.cycle_entry    = rsp_if.cycle_entry;
				n_results++;
				if (got.deadlock_found)
					n_deadlocks++;
				if (expected_verdicts.size() == 0) begin
					$display("%0t: unexpected beat, deadlock_found %0d cycle_entry %0d",
						$time, got.deadlock_found, got.cycle_entry);
					n_errors++;
				end else begin
					want = expected_verdicts.pop_front();
					if (got.deadlock_found !== want.deadlock_found) begin
						$display("%0t: deadlock_found expected %0d actual %0d",
							$time, want.deadlock_found, got.deadlock_found);
						n_errors++;
					end
					if (got.cycle_entry !== want.cycle_entry) begin
						$display("%0t: cycle_entry expected %0d actual %0d",
							$time, want.cycle_entry, got.cycle_entry);
						n_errors++;
					end
				end
				recv_stall = pick_gap();
			end
			if (rsp_hold) begin
				rsp_if.ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// long output back-pressure once, plus stretches with no idling
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_hold <= 1'b0;
			quiet    <= 1'b0;
		end else begin
			cycle_cnt++;
			if (req_if.valid && req_if.ready)
				beats_seen++;
			if (!hold_done && beats_seen >= 700) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0)
				hold_left--;
			rsp_hold <= (hold_left > 0);
			quiet    <= (cycle_cnt[11:9] == 3'b101);
		end
	end

	initial begin
		int pick;
		int len;
		int tail;
		int k;
		int j;
		int tmp;
		int nxt;
		int order[16];

		n_queued    = 0;
		n_accepted  = 0;
		n_checks    = 0;
		n_deadlocks = 0;
		n_results   = 0;
		n_errors    = 0;
		send_gap    = 0;
		recv_stall  = 0;
		cycle_cnt   = 0;
		beats_seen  = 0;
		hold_left   = 0;
		hold_done   = 1'b0;
		for (k = 0; k < N_ENTRIES; k++) begin
			tbl_intro[k] = 1'b0;
			tbl_held[k]  = 1'b0;
			tbl_wait[k]  = 1'b0;
			tbl_tgt[k]   = '0;
		end

		put_check();
		put_write(0, 1, 1, 1, 0);
		put_check();
		put_write(0, 1, 1, 0, 15);
		put_check();
		put_write(15, 1, 1, 1, 0);
		put_write(0, 1, 1, 1, 15);
		put_check();
		put_write(0, 0, 1, 1, 15);
		put_check();
		put_write(0, 1, 0, 1, 15);
		put_check();
		put_write(15, 1, 1, 0, 15);
		put_write(7, 1, 1, 1, 8);
		put_write(8, 1, 1, 1, 9);
		put_write(9, 1, 1, 1, 8);
		put_write(3, 1, 1, 1, 8);
		put_check();
		put_write(8, 1, 1, 0, 9);
		put_check();
		put_write(14, 1, 1, 1, 14);
		put_write(12, 1, 1, 1, 12);
		put_check();
		put_write(15, 1, 1, 1, 14);
		put_check();

		while (n_queued < N_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				// chain over distinct entries, closed into a loop or left open
				for (k = 0; k < 16; k++)
					order[k] = k;
				for (k = 15; k > 0; k--) begin
					j = $urandom_range(0, k);
					tmp = order[k];
					order[k] = order[j];
					order[j] = tmp;
				end
				len = $urandom_range(1, 6);
				tail = $urandom_range(0, 3);
				for (k = 0; k < len; k++) begin
					if (k < len - 1)
						nxt = order[k + 1];
					else if (tail == 0)
						nxt = order[0];
					else if (tail == 1)
						nxt = order[$urandom_range(0, len - 1)];
					else
						nxt = $urandom_range(0, 15);
					put_write(order[k], int'($urandom_range(0, 9) != 0),
						int'($urandom_range(0, 3) != 0), 1, nxt);
				end
				put_check();
				if ($urandom_range(0, 1)) begin
					put_write(order[$urandom_range(0, len - 1)], $urandom_range(0, 1),
						$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 15));
					put_check();
				end
			end else if (pick < 85) begin
				len = $urandom_range(1, 3);
				for (k = 0; k < len; k++)
					put_write($urandom_range(0, 15), $urandom_range(0, 1),
						$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 15));
			end else if (pick < 93) begin
				len = $urandom_range(2, 4);
				for (k = 0; k < len; k++)
					put_write($urandom_range(0, 15), $urandom_range(0, 1),
						$urandom_range(0, 1), 0, $urandom_range(0, 15));
			end else begin
				put_check();
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() != 0 || req_if.valid)
			@(posedge clk);
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("covered %0d beats: %0d writes and %0d checks, %0d of them deadlocked",
			n_accepted, n_accepted - n_checks, n_checks, n_deadlocks);
		$display("%0d results compared, %0d mismatches", n_results, n_errors);
		if (n_errors == 0 && expected_verdicts.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/wfcd_pkg.sv
rtl/core/wfcd_ifs.sv
rtl/core/wfcd_ram.sv
rtl/core/wfcd_ctrl.sv
rtl/core/wfcd_dp.sv
rtl/core/wait_for_cycle_detector.sv
tb/sv/tb_top.sv
